// ===== design/ssoc_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan sector obstacle check package
// Shared widths, constants, codes and types for the sector obstacle check.
// ----------------------------------------------------------------------------
package ssoc_pkg;

    localparam int RANGE_W    = 16;
    localparam int SCAN_LEN_W = 13;
    localparam int INDEX_W    = 12;
    localparam int LEN_W      = 11;
    localparam int SECTOR_W   = 3;
    localparam int ACTION_W   = 3;
    localparam int NUM_SECTORS = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - ACTION_W - NUM_SECTORS * RANGE_W;

    localparam logic [INDEX_W-1:0] MAX_INDEX   = '1;
    localparam logic [RANGE_W-1:0] NO_RETURN   = 16'hFFFF;
    localparam logic [RANGE_W-1:0] MAX_READING = 16'hFFFE;

    // Multiply by RECIP_6 and shift right by RECIP_SHIFT gives x / 6 for 13-bit x.
    localparam int RECIP_6     = 10923;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SCAN_LEN_W + RECIP_W;

    localparam logic [SCAN_LEN_W-1:0] SCAN_LEN_RESET  = 13'd360;
    localparam logic [LEN_W-1:0]      SECTOR_LEN_RESET = 11'd60;
    localparam logic [RANGE_W-1:0]    THRESHOLD_RESET = 16'd800;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd1;

    localparam logic [SECTOR_W-1:0] SEC_RIGHT       = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_FRONT_RIGHT = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_FRONT_LEFT  = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_LEFT        = 3'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BOTH_FRONT_RIGHT = 3'd0,
        ACT_TURN_RIGHT       = 3'd1,
        ACT_TURN_LEFT        = 3'd2,
        ACT_FWD_SLIGHT_RIGHT = 3'd3,
        ACT_FWD_SLIGHT_LEFT  = 3'd4,
        ACT_FORWARD          = 3'd5
    } t_action;

    typedef logic [NUM_SECTORS-1:0][RANGE_W-1:0] t_minima;

    typedef struct packed {
        logic [RANGE_W-1:0]  range_mm;
        logic                sample_valid;
        logic                last_sample;
        logic [SECTOR_W-1:0] sector;
    } t_sample;

endpackage

// ===== design/scan_sector_obstacle_check_unit.sv =====
// ----------------------------------------------------------------------------
// Scan sector obstacle check unit
// Tracks six sector minima over a range scan and reports an action code and
// all six minima on the last sample of each scan.
// ----------------------------------------------------------------------------
// The last sample of a scan passes through the sector stage register and then
// the minima stage result register before its result word is valid.
// Throughput: one input word per cycle; the input stalls only while a last
// sample waits behind a result word that the master side still holds.
// Reset clears the sample count, all minima to 65535, the sector length to 60
// (a scan length of 360) and the threshold to 800; after reset the block accepts words.
module scan_sector_obstacle_check_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssoc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssoc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Sample stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ssoc_pkg::S_TDATA_W-1:0]   i_s_tdata,   // [15:0] range_mm
    input  logic                             i_s_tuser,   // [0] sample_valid
    input  logic                             i_s_tlast,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [2:0] action, [18:3] min_right_rear, [34:19] min_right,
    // [50:35] min_front_right, [66:51] min_front_left, [82:67] min_left,
    // [98:83] min_left_rear, [103:99] zero
    output logic [ssoc_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import ssoc_pkg::*;

    logic [LEN_W-1:0]      r_sector_len;
    logic [RANGE_W-1:0]    r_threshold_mm;
    logic [PROD_W-1:0]     len_prod;
    logic                  cfg_write;
    logic                  s1_valid;
    logic                  s1_ready;
    t_sample               s1_sample;
    t_action               action;
    t_minima               minima;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Sector length is the written scan length divided by six.
    assign len_prod = PROD_W'(i_cfg_data[SCAN_LEN_W-1:0]) * PROD_W'(RECIP_6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_len   <= SECTOR_LEN_RESET;
            r_threshold_mm <= THRESHOLD_RESET;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_SCAN_LENGTH: begin
                    r_sector_len <= len_prod[RECIP_SHIFT +: LEN_W];
                end
                CFG_THRESHOLD: begin
                    r_threshold_mm <= i_cfg_data[RANGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ssoc_sector_stage u_sector_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sector_len   (r_sector_len),
        .i_in_valid     (i_s_tvalid),
        .o_in_ready     (o_s_tready),
        .i_range_mm     (i_s_tdata[RANGE_W-1:0]),
        .i_sample_valid (i_s_tuser),
        .i_last_sample  (i_s_tlast),
        .o_out_valid    (s1_valid),
        .i_out_ready    (s1_ready),
        .o_sample       (s1_sample)
    );

    ssoc_minima_stage u_minima_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold_mm (r_threshold_mm),
        .i_in_valid     (s1_valid),
        .o_in_ready     (s1_ready),
        .i_sample       (s1_sample),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_action       (action),
        .o_minima       (minima)
    );

    assign o_m_tdata = {{M_PAD_W{1'b0}}, minima, action};

endmodule

// ===== design/ssoc_sector_stage.sv =====
// ----------------------------------------------------------------------------
// Sector stage
// Input register: counts samples within the scan and tags each with its sector.
// ----------------------------------------------------------------------------
module ssoc_sector_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ssoc_pkg::LEN_W-1:0]    i_sector_len,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ssoc_pkg::RANGE_W-1:0]  i_range_mm,
    input  logic                          i_sample_valid,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ssoc_pkg::t_sample             o_sample
);
    import ssoc_pkg::*;

    logic [INDEX_W-1:0]    r_index;
    logic                  r_valid;
    t_sample               r_sample;
    logic [SECTOR_W-1:0]   n_sector;
    logic [SCAN_LEN_W-1:0] bound;
    logic                  accept;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_valid;
    assign o_sample    = r_sample;

    // The sector is the number of boundaries k * len (k = 1..5) already reached.
    // A zero sector length puts every sample in the last sector.
    always_comb begin
        n_sector = '0;
        bound    = '0;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            bound = SCAN_LEN_W'(k) * SCAN_LEN_W'(i_sector_len);
            if (SCAN_LEN_W'(r_index) >= bound) begin
                n_sector = n_sector + SECTOR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                if (i_last_sample) begin
                    r_index <= '0;
                end else if (r_index != MAX_INDEX) begin
                    r_index <= r_index + INDEX_W'(1);
                end
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample.range_mm     <= i_range_mm;
            r_sample.sample_valid <= i_sample_valid;
            r_sample.last_sample  <= i_last_sample;
            r_sample.sector       <= n_sector;
        end
    end

endmodule

// ===== design/ssoc_minima_stage.sv =====
// ----------------------------------------------------------------------------
// Minima stage
// Keeps the per-sector minima and registers the action and minima word.
// ----------------------------------------------------------------------------
module ssoc_minima_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ssoc_pkg::RANGE_W-1:0]  i_threshold_mm,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ssoc_pkg::t_sample             i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ssoc_pkg::t_action             o_action,
    output ssoc_pkg::t_minima             o_minima
);
    import ssoc_pkg::*;

    t_minima            r_minima;
    t_minima            n_minima;
    t_minima            r_out_minima;
    t_action            r_action;
    t_action            n_action;
    logic               r_out_valid;
    logic [RANGE_W-1:0] sat_range;
    logic               out_free;
    logic               fire;
    logic               ob_fr;
    logic               ob_fl;
    logic               ob_l;
    logic               ob_r;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !i_sample.last_sample || out_free;
    assign fire        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;
    assign o_minima    = r_out_minima;

    assign sat_range = (i_sample.range_mm == NO_RETURN) ? MAX_READING : i_sample.range_mm;

    always_comb begin
        for (int k = 0; k < NUM_SECTORS; k++) begin
            if (i_sample.sample_valid && (i_sample.sector == SECTOR_W'(k))
                    && (sat_range < r_minima[k])) begin
                n_minima[k] = sat_range;
            end else begin
                n_minima[k] = r_minima[k];
            end
        end
    end

    assign ob_fr = n_minima[SEC_FRONT_RIGHT] < i_threshold_mm;
    assign ob_fl = n_minima[SEC_FRONT_LEFT] < i_threshold_mm;
    assign ob_l  = n_minima[SEC_LEFT] < i_threshold_mm;
    assign ob_r  = n_minima[SEC_RIGHT] < i_threshold_mm;

    always_comb begin
        if (ob_fl && ob_fr) begin
            n_action = ACT_BOTH_FRONT_RIGHT;
        end else if (ob_fl) begin
            n_action = ACT_TURN_RIGHT;
        end else if (ob_fr) begin
            n_action = ACT_TURN_LEFT;
        end else if (ob_l) begin
            n_action = ACT_FWD_SLIGHT_RIGHT;
        end else if (ob_r) begin
            n_action = ACT_FWD_SLIGHT_LEFT;
        end else begin
            n_action = ACT_FORWARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minima    <= {NUM_SECTORS{NO_RETURN}};
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                if (i_sample.last_sample) begin
                    r_minima <= {NUM_SECTORS{NO_RETURN}};
                end else begin
                    r_minima <= n_minima;
                end
            end
            if (fire && i_sample.last_sample) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_sample.last_sample) begin
            r_action     <= n_action;
            r_out_minima <= n_minima;
        end
    end

endmodule

// ===== tb/scan_sector_obstacle_check_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Scan sector obstacle check unit testbench
// Streams range scans into the unit and predicts every result word from its
// own copy of the sector minima, sample count and registers. The scans use
// directed cases for each action code, then random scans under many scan
// lengths and thresholds, with random stalls on both streams and one partial scan
// at a scan length of 4096.
// ----------------------------------------------------------------------------
module scan_sector_obstacle_check_unit_tb;
    import ssoc_pkg::*;

    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 850;
    localparam int HOLD_CYCLES   = 300;
    localparam int LONG_SCAN     = 150;
    localparam int LONG_SCAN_LEN = 4096;

    typedef struct packed {
        t_action action;
        t_minima minima;
    } t_scan_report;

    class scan_sector_scoreboard;
        logic [SCAN_LEN_W-1:0] scan_len;
        logic [RANGE_W-1:0]    thresh;
        logic [INDEX_W-1:0]    idx;
        t_minima               minima;
        t_scan_report          expected_q[$];
        int                    mismatches;
        int                    samples;
        int                    results;
        logic [7:0]            actions_seen;

        function new();
            scan_len     = SCAN_LEN_RESET;
            thresh       = THRESHOLD_RESET;
            mismatches   = 0;
            samples      = 0;
            results      = 0;
            actions_seen = '0;
            clear_scan();
        endfunction

        function void clear_scan();
            idx    = '0;
            minima = {NUM_SECTORS{NO_RETURN}};
        endfunction

        function int unsigned sector_of(int unsigned pos);
            int unsigned len;
            len = scan_len / NUM_SECTORS;
            if (len == 0) return NUM_SECTORS - 1;
            return (pos / len > NUM_SECTORS - 1) ? NUM_SECTORS - 1 : pos / len;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_SCAN_LENGTH: scan_len = data[SCAN_LEN_W-1:0];
                CFG_THRESHOLD:   thresh = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [RANGE_W-1:0] rng, logic ok, logic last);
            t_scan_report       rep;
            int unsigned        s;
            logic [RANGE_W-1:0] r;
            logic               ob_fr, ob_fl, ob_l, ob_r;
            samples++;
            if (ok) begin
                s = sector_of(idx);
                r = (rng == NO_RETURN) ? MAX_READING : rng;
                if (r < minima[s]) minima[s] = r;
            end
            if (!last) begin
                if (idx != MAX_INDEX) idx++;
                return;
            end
            ob_fr = minima[SEC_FRONT_RIGHT] < thresh;
            ob_fl = minima[SEC_FRONT_LEFT] < thresh;
            ob_l  = minima[SEC_LEFT] < thresh;
            ob_r  = minima[SEC_RIGHT] < thresh;
            if (ob_fl && ob_fr) rep.action = ACT_BOTH_FRONT_RIGHT;
            else if (ob_fl) rep.action = ACT_TURN_RIGHT;
            else if (ob_fr) rep.action = ACT_TURN_LEFT;
            else if (ob_l) rep.action = ACT_FWD_SLIGHT_RIGHT;
            else if (ob_r) rep.action = ACT_FWD_SLIGHT_LEFT;
            else rep.action = ACT_FORWARD;
            rep.minima = minima;
            expected_q.push_back(rep);
            clear_scan();
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            t_scan_report rep;
            int           k;
            results++;
            if (expected_q.size() == 0) begin
                note_mismatch($sformatf("Result word %0d arrived with no scan pending: %h",
                                        results, word));
                return;
            end
            rep = expected_q.pop_front();
            actions_seen[rep.action] = 1'b1;
            if (word[ACTION_W-1:0] !== rep.action)
                note_mismatch($sformatf("Result word %0d, action: expected %0d, got %0d",
                                        results, rep.action, word[ACTION_W-1:0]));
            for (k = 0; k < NUM_SECTORS; k++) begin
                if (word[ACTION_W + k*RANGE_W +: RANGE_W] !== rep.minima[k])
                    note_mismatch($sformatf(
                        "Result word %0d, sector %0d minimum: expected %0d, got %0d",
                        results, k, rep.minima[k], word[ACTION_W + k*RANGE_W +: RANGE_W]));
            end
            if (word[M_TDATA_W-1 -: M_PAD_W] !== '0)
                note_mismatch($sformatf("Result word %0d, padding: expected 0, got %h",
                                        results, word[M_TDATA_W-1 -: M_PAD_W]));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata;
    logic                   i_s_tuser;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [M_TDATA_W-1:0]   o_m_tdata;

    scan_sector_scoreboard sb;
    bit quiet;
    int hold_request;
    int hold_left;
    int rx_run;
    int rx_stall;
    int cfg_writes;
    int scans;
    int random_items;

    scan_sector_obstacle_check_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (quiet || $urandom_range(0, 99) < 65) return 0;
        return pick_gap();
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range(logic clear, int unsigned thr);
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        if (clear) return RANGE_W'($urandom_range(thr, 65535));
        r = $urandom_range(0, 99);
        if (r < 5) return NO_RETURN;
        if (r < 8) return MAX_READING;
        if (r < 11) return '0;
        if (r < 60) begin
            lo = (thr > 300) ? thr - 300 : 0;
            hi = (thr + 300 > 65535) ? 65535 : thr + 300;
            return RANGE_W'($urandom_range(lo, hi));
        end
        return RANGE_W'($urandom);
    endfunction

    // Result side: random stalls, quiet stretches, and one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (quiet) begin
            i_m_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else if (rx_run > 0) begin
            rx_run--;
            i_m_tready <= 1'b1;
        end else begin
            rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                                 : $urandom_range(0, 12);
            rx_stall = pick_gap();
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic ok,
                               input logic last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rng;
        i_s_tuser  <= ok;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_sample(rng, ok, last);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(index, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_scan(input int n);
        logic [NUM_SECTORS-1:0] clear_mask;
        int                     i;
        logic [RANGE_W-1:0]     rng;
        logic                   ok;
        clear_mask = NUM_SECTORS'($urandom);
        for (i = 0; i < n; i++) begin
            rng = pick_range(clear_mask[sb.sector_of(i)], sb.thresh);
            ok  = ($urandom_range(0, 99) < 85);
            send_sample(rng, ok, i == n - 1);
        end
        scans++;
    endtask

    initial begin
        int phase;
        int nscans;
        int len;
        int n;
        int j;
        sb = new();
        quiet = 1'b0;
        hold_request = 0;
        hold_left = 0;
        rx_run = 0;
        rx_stall = 0;
        cfg_writes = 0;
        scans = 0;
        random_items = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of both registers, crossing the first sector boundaries.
        run_scan(130);
        drain();

        // One sample per sector: each action code, saturation, invalid samples.
        write_reg(CFG_SCAN_LENGTH, 16'd6);
        write_reg(CFG_THRESHOLD, 16'd800);
        send_sample(16'hFFFF, 1'b1, 1'b1);
        send_sample(16'd0, 1'b1, 1'b0);
        send_sample(16'd5000, 1'b1, 1'b0);
        send_sample(16'd100, 1'b1, 1'b0);
        send_sample(16'd799, 1'b1, 1'b1);
        send_sample(16'd800, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'd800, 1'b1, 1'b0);
        send_sample(16'd10, 1'b1, 1'b1);
        send_sample(16'd900, 1'b1, 1'b0);
        send_sample(16'd900, 1'b1, 1'b0);
        send_sample(16'd0, 1'b1, 1'b1);
        send_sample(16'hFFFE, 1'b1, 1'b0);
        send_sample(16'd801, 1'b1, 1'b0);
        send_sample(16'd801, 1'b1, 1'b0);
        send_sample(16'd801, 1'b1, 1'b0);
        send_sample(16'd1, 1'b1, 1'b1);
        send_sample(16'd2000, 1'b1, 1'b0);
        send_sample(16'd3, 1'b1, 1'b1);
        send_sample(16'd0, 1'b0, 1'b0);
        send_sample(16'd0, 1'b0, 1'b1);
        drain();
        // Scan shorter than six samples: everything lands in the last sector.
        write_reg(CFG_SCAN_LENGTH, 16'd5);
        send_sample(16'd700, 1'b1, 1'b0);
        send_sample(16'd100, 1'b1, 1'b1);
        drain();

        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = $urandom_range(2, 5);
                2: len = 6;
                3: len = 7;
                4: len = $urandom_range(49, 4096);
                default: len = $urandom_range(8, 48);
            endcase
            if (phase == 2) len = 6;
            write_reg(CFG_SCAN_LENGTH, CFG_DATA_W'(len));
            if ($urandom_range(0, 9) < 7 || phase == 0) begin
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_THRESHOLD, 16'd0);
                    1: write_reg(CFG_THRESHOLD, 16'd65534);
                    2: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 65534)));
                    default: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(200, 3000)));
                endcase
            end
            quiet = ($urandom_range(0, 4) == 0);
            if (phase == 2) begin
                // Results are held back while every word closes a scan.
                quiet = 1'b1;
                hold_request = HOLD_CYCLES;
                for (j = 0; j < 40; j++) run_scan(1);
                random_items += 40;
            end
            nscans = $urandom_range(2, 6);
            for (j = 0; j < nscans; j++) begin
                if (len > 64) n = $urandom_range(1, 64);
                else if ($urandom_range(0, 99) < 70) n = len;
                else if ($urandom_range(0, 1) == 0) n = $urandom_range(1, len);
                else n = len + $urandom_range(1, 10);
                run_scan(n);
                random_items += n;
                if (phase == 3 && j == 0) drain();
            end
            drain();
            phase++;
        end

        // Scan length 4096, with one partial scan in its first sector.
        quiet = 1'b0;
        write_reg(CFG_SCAN_LENGTH, CFG_DATA_W'(LONG_SCAN_LEN));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(500, 1500)));
        run_scan(LONG_SCAN);
        drain();

        $display("Covered %0d samples in %0d scans, %0d result words, %0d register writes.",
                 sb.samples, scans, sb.results, cfg_writes);
        $display("Action codes seen (bit per code): %b; scan lengths 1 to %0d were used.",
                 sb.actions_seen[5:0], LONG_SCAN_LEN);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches in total.", sb.mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
